FILE: sv/spc_pkg.sv
// Package for the sample playback controller: types, codes and constants.
`default_nettype none

package spc_pkg;

  // Player state
  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_PLAYING = 2'd1,
    ST_PAUSED  = 2'd2
  } play_state_t;

  // Request kinds carried on the input tuser
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_PAUSE  = 3'd1;
  localparam logic [2:0] MODE_RESUME = 3'd2;
  localparam logic [2:0] MODE_STOP   = 3'd3;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  // Event codes on the result
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_ACCEPT = 3'd1;
  localparam logic [2:0] EV_REFUSE = 3'd2;
  localparam logic [2:0] EV_END    = 3'd3;
  localparam logic [2:0] EV_ERROR  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_CLIP_LENGTH    = 2'd0;
  localparam logic [1:0] REG_GAIN           = 2'd1;
  localparam logic [1:0] REG_SOURCE_PRESENT = 2'd2;

  // Sample arithmetic
  localparam logic [7:0]  MIDPOINT   = 8'd128;
  localparam logic [6:0]  UNITY_GAIN = 7'd127;
  // floor(m / 127) == (m * RECIP_127) >> RECIP_SHIFT for m up to 128 * 127
  localparam logic [14:0] RECIP_127   = 15'd16514;
  localparam int          RECIP_SHIFT = 21;

  // Request widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

endpackage

`default_nettype wire

FILE: sv/sample_playback_controller_unit.sv
// Sample playback controller: command decode, state update and gain scaling.
// An accepted request is registered in stage 1, then in the result register that drives m_tvalid.
// Throughput: one request per cycle unless stalled; the control state is updated at
// acceptance, and the gain multiply and constant divide by 127 each take one stage.
// Reset: stopped at offset 0, clip length 0, gain 127, no source, pipeline empty.
`default_nettype none

module sample_playback_controller_unit (
  input  wire                           clk,
  input  wire                           rst,
  // Input requests
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [spc_pkg::IN_DATA_W-1:0] s_tdata,   // sample_byte[7:0], fetch_failed[8]
  input  wire  [2:0]                    s_tuser,   // mode[2:0]
  // Result requests
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [spc_pkg::OUT_DATA_W-1:0] m_tdata,  // scaled_sample[7:0], event_code[10:8],
                                                   // player_state[12:11], next_offset[44:13]
  output logic [0:0]                    m_tuser,   // sample_valid[0]
  // Configuration writes
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [1:0]                    cfg_index,
  input  wire  [31:0]                   cfg_data
);
  import spc_pkg::*;

  // Configuration registers
  logic [31:0] clip_length;
  logic [6:0]  gain;
  logic        source_present;

  // Player state
  play_state_t play_state, play_state_next;
  logic [31:0] byte_offset, byte_offset_next;

  // Stage 1 (after acceptance)
  logic        s1_valid;
  logic        s1_sample_valid;
  logic        s1_negative;
  logic [13:0] s1_magnitude;
  logic [2:0]  s1_event;
  logic [1:0]  s1_state;
  logic [31:0] s1_offset;

  // Decode of the incoming request
  logic [2:0]  in_mode;
  logic [7:0]  in_byte;
  logic        in_failed;
  logic        in_accept;
  logic        out_free;
  logic        s1_advance;
  logic [2:0]  event_next;
  logic        sample_valid_next;
  logic        negative;
  logic [7:0]  centred_mag;

  // Stage 2 arithmetic
  logic [28:0] recip_product;
  logic [7:0]  quotient;
  logic [8:0]  scaled_wide;

  assign in_mode   = s_tuser;
  assign in_byte   = s_tdata[7:0];
  assign in_failed = s_tdata[8];

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_length    <= '0;
      gain           <= UNITY_GAIN;
      source_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CLIP_LENGTH:    clip_length    <= cfg_data;
        REG_GAIN:           gain           <= cfg_data[6:0];
        REG_SOURCE_PRESENT: source_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free   = !m_tvalid || m_tready;
  assign s1_advance = s1_valid && out_free;
  assign s_tready   = !s1_valid || out_free;
  assign in_accept  = s_tvalid && s_tready;

  // Next state, offset and event for the request at the input
  always_comb begin
    play_state_next   = play_state;
    byte_offset_next  = byte_offset;
    event_next        = EV_NONE;
    sample_valid_next = 1'b0;
    unique case (in_mode)
      MODE_START: begin
        if (clip_length == '0 || !source_present) begin
          event_next = EV_REFUSE;
        end else begin
          play_state_next  = ST_PLAYING;
          byte_offset_next = '0;
          event_next       = EV_ACCEPT;
        end
      end
      MODE_PAUSE: begin
        if (play_state == ST_PLAYING) begin
          play_state_next = ST_PAUSED;
          event_next      = EV_ACCEPT;
        end else begin
          event_next = EV_REFUSE;
        end
      end
      MODE_RESUME: begin
        if (play_state == ST_PAUSED) begin
          play_state_next = ST_PLAYING;
          event_next      = EV_ACCEPT;
        end else begin
          event_next = EV_REFUSE;
        end
      end
      MODE_STOP: begin
        play_state_next  = ST_STOPPED;
        byte_offset_next = '0;
        event_next       = EV_ACCEPT;
      end
      MODE_SAMPLE: begin
        if (play_state == ST_PLAYING) begin
          if (byte_offset == clip_length) begin
            play_state_next  = ST_STOPPED;
            byte_offset_next = '0;
            event_next       = EV_END;
          end else if (in_failed) begin
            play_state_next  = ST_STOPPED;
            byte_offset_next = '0;
            event_next       = EV_ERROR;
          end else begin
            sample_valid_next = 1'b1;
            byte_offset_next  = byte_offset + 32'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Byte centred on the midpoint, as sign and magnitude
  assign negative    = (in_byte < MIDPOINT);
  assign centred_mag = negative ? (MIDPOINT - in_byte) : (in_byte - MIDPOINT);

  // Player state register
  always_ff @(posedge clk) begin
    if (rst) begin
      play_state  <= ST_STOPPED;
      byte_offset <= '0;
    end else if (in_accept) begin
      play_state  <= play_state_next;
      byte_offset <= byte_offset_next;
    end
  end

  // Stage 1: control result and gain product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_valid <= sample_valid_next;
      s1_negative     <= negative;
      s1_magnitude    <= 14'(centred_mag * gain);
      s1_event        <= event_next;
      s1_state        <= play_state_next;
      s1_offset       <= byte_offset_next;
    end
  end

  // Stage 2: divide by 127 with truncation toward zero, re-centre
  assign recip_product = 29'(s1_magnitude * RECIP_127);
  assign quotient      = recip_product[RECIP_SHIFT +: 8];
  assign scaled_wide   = s1_negative ? ({1'b0, MIDPOINT} - {1'b0, quotient})
                                     : ({1'b0, MIDPOINT} + {1'b0, quotient});

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tuser[0]     <= s1_sample_valid;
      m_tdata[7:0]   <= s1_sample_valid ? scaled_wide[7:0] : MIDPOINT;
      m_tdata[10:8]  <= s1_event;
      m_tdata[12:11] <= s1_state;
      m_tdata[44:13] <= s1_offset;
      m_tdata[47:45] <= '0;
    end
  end

endmodule

`default_nettype wire
